// File: hw/rtl/ring_buffer_deque_core_defines.svh
// Assertion macros for the ring buffer deque top level.
`ifndef RING_BUFFER_DEQUE_CORE_DEFINES_SVH
`define RING_BUFFER_DEQUE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RBD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define RBD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/rbd_pkg.sv
// Shared constants, codes and command type for the ring buffer deque.
package rbd_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int PTR_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int CAP_W      = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef enum logic [2:0] {
		MODE_PUSH_BACK  = 3'd0,
		MODE_PUSH_FRONT = 3'd1,
		MODE_POP_BACK   = 3'd2,
		MODE_POP_FRONT  = 3'd3,
		MODE_PEEK_BACK  = 3'd4,
		MODE_PEEK_FRONT = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic load;
		logic exec;
	} rbd_cmd_t;

endpackage

// File: hw/rtl/rbd_ctrl.sv
// Request sequencer: input acceptance, execute step and output valid.
module rbd_ctrl
	import rbd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output rbd_cmd_t cmd
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign cmd.load  = in_valid && (state_q == S_IDLE);
	assign cmd.exec  = (state_q == S_EXEC) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (cmd.exec) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (cmd.exec) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// File: hw/rtl/rbd_datapath.sv
// Slot store, head/tail pointers, fill count and result registers.
module rbd_datapath
	import rbd_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  rbd_cmd_t                     cmd,
	input  logic [2:0]                   mode,
	input  logic signed [DATA_WIDTH-1:0] data_in,
	input  logic                         capacity_wr_en,
	input  logic [CAP_W-1:0]             capacity_wr_data,
	output logic signed [DATA_WIDTH-1:0] data_out,
	output logic [1:0]                   status,
	output logic [CNT_W-1:0]             fill_level,
	output logic                         is_empty_flag,
	output logic                         is_full_flag
);

	logic [DATA_WIDTH-1:0] slot_q [DEPTH];
	logic [DATA_WIDTH-1:0] rd_data_q;
	logic [DATA_WIDTH-1:0] data_q;
	mode_t                 mode_q;
	logic [CAP_W-1:0]      cap_q;
	logic [PTR_W-1:0]      head_q, tail_q;
	logic [CNT_W-1:0]      fill_q;
	logic [DATA_WIDTH-1:0] dout_q;
	status_t               status_q;
	logic                  empty_q, full_q;

	logic [CNT_W-1:0]      cap_eff;
	logic [PTR_W-1:0]      head_d, tail_d, wr_ptr, rd_ptr;
	logic [CNT_W-1:0]      fill_d;
	status_t               status_d;
	logic [DATA_WIDTH-1:0] dout_d;
	logic                  wr_en;
	mode_t                 mode_in;

	function automatic logic [PTR_W-1:0] wrap_inc(logic [PTR_W-1:0] p, logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] nxt;
		nxt = CNT_W'(p) + CNT_W'(1);
		return (nxt >= cap) ? '0 : nxt[PTR_W-1:0];
	endfunction

	function automatic logic [PTR_W-1:0] wrap_dec(logic [PTR_W-1:0] p, logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] last;
		last = cap - CNT_W'(1);
		return (p == '0 || CNT_W'(p) > cap) ? last[PTR_W-1:0] : p - PTR_W'(1);
	endfunction

	assign mode_in = mode_t'(mode);
	assign rd_ptr  = (mode_in == MODE_POP_BACK || mode_in == MODE_PEEK_BACK) ? tail_q : head_q;

	always_comb begin
		if (cap_q == '0) cap_eff = CNT_W'(1);
		else if (CNT_W'(cap_q) > CNT_W'(DEPTH)) cap_eff = CNT_W'(DEPTH);
		else cap_eff = CNT_W'(cap_q);
	end

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		fill_d   = fill_q;
		status_d = ST_OK;
		dout_d   = '0;
		wr_en    = 1'b0;
		wr_ptr   = tail_q;
		case (mode_q) inside
			MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
				if (fill_q >= cap_eff) begin
					status_d = ST_FULL;
				end else begin
					if (fill_q == '0) begin
						head_d = '0;
						tail_d = '0;
						wr_ptr = '0;
					end else if (mode_q == MODE_PUSH_BACK) begin
						tail_d = wrap_inc(tail_q, cap_eff);
						wr_ptr = tail_d;
					end else begin
						head_d = wrap_dec(head_q, cap_eff);
						wr_ptr = head_d;
					end
					wr_en  = 1'b1;
					fill_d = fill_q + CNT_W'(1);
				end
			end
			MODE_POP_BACK, MODE_POP_FRONT, MODE_PEEK_BACK, MODE_PEEK_FRONT: begin
				if (fill_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					dout_d = rd_data_q;
					if (mode_q == MODE_POP_BACK || mode_q == MODE_POP_FRONT) begin
						if (fill_q == CNT_W'(1)) begin
							head_d = '0;
							tail_d = '0;
						end else if (mode_q == MODE_POP_BACK) begin
							tail_d = wrap_dec(tail_q, cap_eff);
						end else begin
							head_d = wrap_inc(head_q, cap_eff);
						end
						fill_d = fill_q - CNT_W'(1);
					end
				end
			end
			default: ;
		endcase
	end

	// Slot store: read on input transfer, written on execute.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rd_data_q <= slot_q[rd_ptr];
			mode_q    <= mode_in;
			data_q    <= data_in;
		end
		if (cmd.exec && wr_en) slot_q[wr_ptr] <= data_q;
		if (cmd.exec) begin
			dout_q <= dout_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CAP_RESET;
			head_q   <= '0;
			tail_q   <= '0;
			fill_q   <= '0;
			status_q <= ST_OK;
			empty_q  <= 1'b1;
			full_q   <= 1'b0;
		end else begin
			if (capacity_wr_en) cap_q <= capacity_wr_data;
			if (cmd.exec) begin
				head_q   <= head_d;
				tail_q   <= tail_d;
				fill_q   <= fill_d;
				status_q <= status_d;
				empty_q  <= (fill_d == '0);
				full_q   <= (fill_d >= cap_eff);
			end
		end
	end

	assign data_out      = dout_q;
	assign status        = status_q;
	assign fill_level    = fill_q;
	assign is_empty_flag = empty_q;
	assign is_full_flag  = full_q;

endmodule

// File: hw/rtl/ring_buffer_deque_core.sv
// Top level of the ring buffer deque.
// Double-ended queue over a 16-slot ring of 32-bit elements, of which the first
// "capacity" slots are used (0 acts as 1, above 16 acts as 16). One request is in
// flight at a time: the transfer edge reads the end slot the request addresses,
// and the execute edge updates pointers and fill count, writes the slot and loads
// the result into the output register, which presents it. A new request is not
// taken until the one before it has executed. The next request is taken while a
// result waits on out_ready; its update then waits until that result is transferred.
// Rejected pushes (full) and pops or peeks (empty) change nothing and flag status.
// No clearing pass after reset; the user must write capacity only when idle, which
// the block itself does not enforce.
`include "ring_buffer_deque_core_defines.svh"
module ring_buffer_deque_core
	import rbd_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [2:0]                   mode,
	input  logic signed [DATA_WIDTH-1:0] data_in,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0] data_out,
	output logic [1:0]                   status,
	output logic [CNT_W-1:0]             fill_level,
	output logic                         is_empty_flag,
	output logic                         is_full_flag,
	input  logic                         capacity_wr_en,
	input  logic [CAP_W-1:0]             capacity_wr_data
);

	rbd_cmd_t cmd;

	rbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	rbd_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.mode             (mode),
		.data_in          (data_in),
		.capacity_wr_en   (capacity_wr_en),
		.capacity_wr_data (capacity_wr_data),
		.data_out         (data_out),
		.status           (status),
		.fill_level       (fill_level),
		.is_empty_flag    (is_empty_flag),
		.is_full_flag     (is_full_flag)
	);

	`RBD_ASSERT_NXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready, "second transfer while busy")
	`RBD_ASSERT_IMP(a_fill_bound, clk, arst_n, out_valid, fill_level <= CNT_W'(DEPTH), "fill level above depth")
	`RBD_ASSERT_IMP(a_empty_flag, clk, arst_n, out_valid, is_empty_flag == (fill_level == '0), "empty flag mismatch")
	`RBD_ASSERT_IMP(a_err_zero, clk, arst_n, out_valid && status != ST_OK, data_out == '0, "error result carries data")

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for ring_buffer_deque_core: directed and random deque traffic.
module tb_top
	import rbd_pkg::*;
();

	localparam int CLK_PERIOD = 8;
	localparam logic [2:0] MODE_SPARE_LO = 3'd6;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;

	typedef enum int {
		IDLE_NONE,
		IDLE_SOME,
		IDLE_HEAVY
	} idle_style_t;

	typedef struct packed {
		logic [2:0]            op;
		logic [DATA_WIDTH-1:0] val;
	} deque_req_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] data;
		status_t               st;
		logic [CNT_W-1:0]      level;
		logic                  empty;
		logic                  full;
	} deque_result_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic [2:0]                   mode = MODE_PUSH_BACK;
	logic signed [DATA_WIDTH-1:0] data_in = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic signed [DATA_WIDTH-1:0] data_out;
	logic [1:0]                   status;
	logic [CNT_W-1:0]             fill_level;
	logic                         is_empty_flag;
	logic                         is_full_flag;
	logic                         capacity_wr_en = 1'b0;
	logic [CAP_W-1:0]             capacity_wr_data = CAP_RESET;

	// model state
	logic [DATA_WIDTH-1:0] ring_model [DEPTH];
	int                    head_pos = 0;
	int                    tail_pos = 0;
	int                    elem_count = 0;
	logic [CAP_W-1:0]      cap_setting = CAP_RESET;

	deque_req_t    request_queue [$];
	deque_result_t pending_results [$];
	deque_req_t    next_req;
	deque_result_t next_result;
	deque_result_t want;

	idle_style_t send_style = IDLE_SOME;
	idle_style_t recv_style = IDLE_SOME;
	int          send_wait = 0;
	int          recv_wait = 0;
	int          stall_draw;

	int err_count = 0;
	int sent_count = 0;
	int checked_count = 0;
	int cap_writes = 0;
	int full_refusals = 0;
	int empty_refusals = 0;

	logic [DATA_WIDTH-1:0] corner_words [6];

	ring_buffer_deque_core i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.mode             (mode),
		.data_in          (data_in),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.data_out         (data_out),
		.status           (status),
		.fill_level       (fill_level),
		.is_empty_flag    (is_empty_flag),
		.is_full_flag     (is_full_flag),
		.capacity_wr_en   (capacity_wr_en),
		.capacity_wr_data (capacity_wr_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int usable_slots(input logic [CAP_W-1:0] c);
		if (c == 0) return 1;
		if (c > DEPTH) return DEPTH;
		return int'(c);
	endfunction

	function automatic int step_up(input int p, input int c);
		return (p + 1 >= c) ? 0 : p + 1;
	endfunction

	function automatic int step_down(input int p, input int c);
		return (p == 0 || p > c) ? c - 1 : p - 1;
	endfunction

	// Applies one request to the model deque and returns the result it should produce.
	function automatic deque_result_t deque_apply(input logic [2:0] op,
			input logic [DATA_WIDTH-1:0] val);
		deque_result_t r;
		int            c;
		logic          at_back;
		c = usable_slots(cap_setting);
		r = '0;
		r.st = ST_OK;
		at_back = (op == MODE_POP_BACK || op == MODE_PEEK_BACK);
		case (op)
			MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
				if (elem_count >= c) begin
					r.st = ST_FULL;
				end else begin
					if (elem_count == 0) begin
						head_pos = 0;
						tail_pos = 0;
					end else if (op == MODE_PUSH_BACK) begin
						tail_pos = step_up(tail_pos, c);
					end else begin
						head_pos = step_down(head_pos, c);
					end
					ring_model[(op == MODE_PUSH_BACK) ? tail_pos : head_pos] = val;
					elem_count++;
				end
			end
			MODE_POP_BACK, MODE_POP_FRONT, MODE_PEEK_BACK, MODE_PEEK_FRONT: begin
				if (elem_count == 0) begin
					r.st = ST_EMPTY;
				end else begin
					r.data = ring_model[at_back ? tail_pos : head_pos];
					if (op == MODE_POP_BACK || op == MODE_POP_FRONT) begin
						if (elem_count == 1) begin
							head_pos = 0;
							tail_pos = 0;
						end else if (at_back) begin
							tail_pos = step_down(tail_pos, c);
						end else begin
							head_pos = step_up(head_pos, c);
						end
						elem_count--;
					end
				end
			end
			default: ;
		endcase
		r.level = elem_count[CNT_W-1:0];
		r.empty = (elem_count == 0);
		r.full = (elem_count >= c);
		return r;
	endfunction

	function automatic int draw_wait(input idle_style_t style);
		if (style == IDLE_NONE) return 0;
		if (style == IDLE_SOME && $urandom_range(0, 3) != 0) return 0;
		return $urandom_range(0, 12);
	endfunction

	function automatic logic [DATA_WIDTH-1:0] pick_word();
		if ($urandom_range(0, 7) == 0) return corner_words[$urandom_range(0, 5)];
		return $urandom;
	endfunction

	task automatic flag_mismatch(input string what);
		if (err_count < 40) $display("mismatch at result %0d: %s", checked_count, what);
		err_count++;
	endtask

	task automatic add_request(input logic [2:0] op, input logic [DATA_WIDTH-1:0] val);
		request_queue.insert(request_queue.size(), {op, val});
	endtask

	task automatic wait_drained();
		while (request_queue.size() != 0 || in_valid || pending_results.size() != 0)
			@(negedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] v);
		@(posedge clk);
		capacity_wr_en <= 1'b1;
		capacity_wr_data <= v;
		cap_setting = v;
		cap_writes++;
		@(posedge clk);
		capacity_wr_en <= 1'b0;
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			mode <= MODE_PUSH_BACK;
			data_in <= '0;
			send_wait <= 0;
		end else begin
			if (in_valid && in_ready) begin
				next_result = deque_apply(mode, data_in);
				if (next_result.st == ST_FULL) full_refusals++;
				if (next_result.st == ST_EMPTY) empty_refusals++;
				pending_results.insert(pending_results.size(), next_result);
				sent_count++;
			end
			if (!in_valid || in_ready) begin
				if (send_wait > 0) begin
					in_valid <= 1'b0;
					send_wait <= send_wait - 1;
				end else if (request_queue.size() > 0) begin
					next_req = request_queue[0];
					request_queue.delete(0);
					in_valid <= 1'b1;
					mode <= next_req.op;
					data_in <= next_req.val;
					send_wait <= draw_wait(send_style);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_wait <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					flag_mismatch($sformatf("unexpected transfer, data_out %h", data_out));
				end else begin
					want = pending_results[0];
					pending_results.delete(0);
					if (data_out !== want.data)
						flag_mismatch($sformatf("data_out %h, expected %h", data_out, want.data));
					if (status !== want.st)
						flag_mismatch($sformatf("status %0d, expected %s", status,
							want.st.name()));
					if (fill_level !== want.level)
						flag_mismatch($sformatf("fill_level %0d, expected %0d", fill_level,
							want.level));
					if (is_empty_flag !== want.empty)
						flag_mismatch($sformatf("is_empty_flag %b, expected %b", is_empty_flag,
							want.empty));
					if (is_full_flag !== want.full)
						flag_mismatch($sformatf("is_full_flag %b, expected %b", is_full_flag,
							want.full));
				end
				checked_count++;
				stall_draw = draw_wait(recv_style);
				recv_wait <= stall_draw;
				out_ready <= (stall_draw == 0);
			end else if (recv_wait > 0) begin
				recv_wait <= recv_wait - 1;
				out_ready <= (recv_wait == 1);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int               p;
		int               k;
		int               lim;
		int               seg_len;
		int               counted;
		logic [2:0]       op;
		logic [CAP_W-1:0] new_cap;
		corner_words[0] = 32'h8000_0000;
		corner_words[1] = 32'h7fff_ffff;
		corner_words[2] = 32'h0000_0000;
		corner_words[3] = 32'hffff_ffff;
		corner_words[4] = 32'h5555_5555;
		corner_words[5] = 32'haaaa_aaaa;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset capacity: fill every slot, then overflow, peeks and spare modes
		for (k = 0; k < DEPTH; k++)
			add_request(MODE_PUSH_BACK, (k < 6) ? corner_words[k] : $urandom);
		add_request(MODE_PUSH_FRONT, $urandom);
		add_request(MODE_PEEK_BACK, $urandom);
		add_request(MODE_PEEK_FRONT, $urandom);
		add_request(MODE_SPARE_LO, $urandom);
		add_request(MODE_SPARE_HI, $urandom);
		wait_drained();

		// capacity zero acts as one and sits below the fill level
		write_capacity('0);
		add_request(MODE_PUSH_FRONT, $urandom);
		add_request(MODE_POP_BACK, $urandom);
		add_request(MODE_POP_FRONT, $urandom);

		for (p = 0; p < 10; p++) begin
			wait_drained();
			case (p)
				0: new_cap = 5'd31;
				1: new_cap = 5'd1;
				2: new_cap = 5'd16;
				3: new_cap = 5'd7;
				4: new_cap = 5'd0;
				5: new_cap = 5'd2;
				6: new_cap = 5'd24;
				7: new_cap = 5'd16;
				8: new_cap = 5'd12;
				default: new_cap = CAP_W'($urandom_range(1, DEPTH));
			endcase
			write_capacity(new_cap);
			send_style = idle_style_t'(p % 3);
			recv_style = idle_style_t'((p + p / 3) % 3);
			lim = usable_slots(new_cap);
			counted = 0;
			// alternating push and pop bursts drive the deque between empty and full
			while (counted < 120) begin
				seg_len = $urandom_range(0, lim + 2);
				for (k = 0; k < seg_len; k++) begin
					if ($urandom_range(0, 19) == 0) begin
						op = 3'($urandom_range(0, 7));
					end else begin
						op = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
					end
					add_request(op, pick_word());
					if (op <= MODE_PEEK_FRONT) counted++;
				end
				seg_len = $urandom_range(0, 2 * lim + 3);
				for (k = 0; k < seg_len; k++) begin
					case ($urandom_range(0, 5))
						0, 1: op = MODE_POP_BACK;
						2, 3: op = MODE_POP_FRONT;
						4: op = MODE_PEEK_BACK;
						default: op = MODE_PEEK_FRONT;
					endcase
					if ($urandom_range(0, 19) == 0) op = 3'($urandom_range(0, 7));
					add_request(op, pick_word());
					if (op <= MODE_PEEK_FRONT) counted++;
				end
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		$display("Ran %0d requests through %0d capacity settings; %0d results checked.",
			sent_count, cap_writes + 1, checked_count);
		$display("Refused pushes when full: %0d, refused pops/peeks when empty: %0d,",
			full_refusals, empty_refusals);
		$display("mismatches: %0d.", err_count);
		if (err_count == 0) begin
			$display("[ring_buffer_deque_core] OK");
		end else begin
			$display("[ring_buffer_deque_core] ERROR");
		end
		$finish;
	end

	initial begin
		#(CLK_PERIOD * 400000);
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("[ring_buffer_deque_core] ERROR");
		$finish;
	end

endmodule
